// ----- hdl/gasi_pkg.sv -----
// Shared types and constants for the gapped array shift-insert block.
package gasi_pkg;

  // Row geometry
  localparam int CELLS    = 256;
  localparam int KEY_BITS = 16;
  localparam int POS_BITS = $clog2(CELLS + 1);
  localparam int IDX_BITS = $clog2(CELLS);

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Input beat
  typedef struct packed {
    logic                operation;
    logic [POS_BITS-1:0] position;
    logic [KEY_BITS-1:0] key;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [KEY_BITS-1:0] cell_value;
    logic [POS_BITS-1:0] used_length;
    logic                overflow;
  } out_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic                ins;   // commit an insert this cycle
    logic                rd;    // drive the read bus this cycle
    logic [IDX_BITS-1:0] p;     // insert slot (0-based)
    logic [IDX_BITS-1:0] ra;    // read slot (0-based)
  } cell_ctl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

// ----- hdl/gasi_cell.sv -----
// One cell of the row: holds a key, shifts in from its left neighbor on insert.
module gasi_cell import gasi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDX_BITS-1:0] idx,
  input  cell_ctl_t           ctl,
  input  logic [KEY_BITS-1:0] key,
  input  logic [KEY_BITS-1:0] left,
  input  logic                span,
  output logic [KEY_BITS-1:0] data_o,
  output logic                fill_o,
  output logic [KEY_BITS-1:0] rd_o
);

  logic [KEY_BITS-1:0] data_r;
  logic [KEY_BITS-1:0] data_nxt;
  logic                below;
  logic                is_p;

  assign below = idx < ctl.p;
  assign is_p  = idx == ctl.p;

  // Cells below the slot count as full so the carry skips them
  assign fill_o = below | (data_r != '0);
  assign data_o = data_r;
  assign rd_o   = (ctl.rd && (idx == ctl.ra)) ? data_r : '0;

  // Key lands at the slot; cells between slot and first gap take the left value
  always_comb begin
    data_nxt = data_r;
    priority if (ctl.ins && is_p) begin
      data_nxt = key;
    end else if (ctl.ins && span && !below) begin
      data_nxt = left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- hdl/gapped_array_shift_insert.sv -----
// Top level: gapped row of key cells with positional insert and read.
//
// Usage: present a beat on in_item and raise start while busy is low; the
// beat is taken at that clock edge. in_item.operation selects insert or read,
// in_item.position is the 1-based cell, in_item.key the value to insert.
// Exactly one result beat follows per input beat: out_strobe is high for one
// cycle with out_item holding cell_value, used_length and overflow.
// Sequence: a taken beat moves the sequencer to ST_EXEC, and out_strobe is
// registered as it returns to ST_IDLE; busy is low again in the cycle that
// out_strobe is high, and no new beat is taken while one is in ST_EXEC, which
// resolves the first gap at or after the slot with one carry across the whole
// row and shifts every affected cell at once.
// Reset (rst_n low, synchronous) empties every cell, clears the length and
// returns to idle; no result is pending afterwards.
// The receiver cannot stall: each result is strobed for one cycle only.
module gapped_array_shift_insert import gasi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_strobe,
  output out_t out_item
);

  state_t              state_r, state_nxt;
  in_t                 req_r;
  logic [POS_BITS-1:0] length_r, length_nxt;
  logic                out_strobe_r;
  out_t                out_item_r, out_item_nxt;

  logic [POS_BITS-1:0] pos_eff, p_full, rd_pm1, len0;
  logic                too_far, rd_ok, is_ins, no_gap, ovf, grow;
  logic [CELLS-1:0]    fill, span;
  logic [CELLS:0]      sum;
  logic [KEY_BITS-1:0] rd_val;
  cell_ctl_t           ctl;

  logic [KEY_BITS-1:0] chain  [CELLS];
  logic [KEY_BITS-1:0] rd_bus [CELLS];

  assign busy       = state_r == ST_EXEC;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Slot decode: position zero inserts at the first cell
  assign pos_eff = (req_r.position == '0) ? POS_BITS'(1) : req_r.position;
  assign too_far = pos_eff > POS_BITS'(CELLS);
  assign p_full  = pos_eff - POS_BITS'(1);
  assign rd_pm1  = req_r.position - POS_BITS'(1);
  assign rd_ok   = (req_r.position != '0) && (req_r.position <= POS_BITS'(CELLS));
  assign len0    = (length_r < pos_eff) ? pos_eff : length_r;

  // First gap at or after the slot: carry through the run of full cells
  assign sum    = {1'b0, fill} + (CELLS + 1)'(1);
  assign span   = fill ^ sum[CELLS-1:0];
  assign no_gap = sum[CELLS];

  assign is_ins = (state_r == ST_EXEC) && (req_r.operation == OP_INSERT);
  assign ovf    = too_far || no_gap;
  // Row grows when the shift reaches the cell just past the padded length
  assign grow   = (len0 < POS_BITS'(CELLS)) && span[len0[IDX_BITS-1:0]];

  always_comb begin
    ctl.ins = is_ins && !ovf;
    ctl.rd  = (state_r == ST_EXEC) && (req_r.operation == OP_READ) && rd_ok;
    ctl.p   = p_full[IDX_BITS-1:0];
    ctl.ra  = rd_pm1[IDX_BITS-1:0];
  end

  // Row of cells
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    if (g == 0) begin : g_head
      gasi_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .idx    (IDX_BITS'(g)),
        .ctl    (ctl),
        .key    (req_r.key),
        .left   ('0),
        .span   (span[g]),
        .data_o (chain[g]),
        .fill_o (fill[g]),
        .rd_o   (rd_bus[g])
      );
    end else begin : g_body
      gasi_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .idx    (IDX_BITS'(g)),
        .ctl    (ctl),
        .key    (req_r.key),
        .left   (chain[g-1]),
        .span   (span[g]),
        .data_o (chain[g]),
        .fill_o (fill[g]),
        .rd_o   (rd_bus[g])
      );
    end
  end

  // Read bus: only the addressed cell drives nonzero
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CELLS; i++) begin
      rd_val = rd_val | rd_bus[i];
    end
  end

  // Sequencer, length and result
  always_comb begin
    state_nxt    = state_r;
    length_nxt   = length_r;
    out_item_nxt = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        if (ctl.ins) begin
          length_nxt = len0 + POS_BITS'(grow);
        end
        out_item_nxt.cell_value  = rd_val;
        out_item_nxt.used_length = length_nxt;
        out_item_nxt.overflow    = is_ins && ovf;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      length_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      length_r     <= length_nxt;
      out_strobe_r <= state_r == ST_EXEC;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  // Checks
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_strobe |-> $past(state_r == ST_EXEC))
    else $error("result strobe without an executed beat");

  a_accept_to_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not start execution");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= POS_BITS'(CELLS))
    else $error("used length beyond row size");

  a_length_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> length_r >= $past(length_r))
    else $error("used length shrank");

  a_refused_keeps_length: assert property (@(posedge clk) disable iff (!rst_n)
    is_ins && ovf |=> length_r == $past(length_r))
    else $error("refused insert changed the length");

endmodule
